// ===== hdl/hmm_viterbi_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// HMM Viterbi decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HMM_VITERBI_DECODER_DEFINES_SVH
`define HMM_VITERBI_DECODER_DEFINES_SVH

// Same-cycle implication.
`define HVD_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HVD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/hvd_pkg.sv =====
// ----------------------------------------------------------------------------
// HMM Viterbi decoder package
// Fixed widths, register map, controller states and command/status words.
// ----------------------------------------------------------------------------
`default_nettype none

package hvd_pkg;

	localparam int IN_W         = 32;  // log_potential width
	localparam int LP_W         = 32;  // path_score width
	localparam int STATE_W      = 3;   // state_index width
	localparam int APB_DW       = 32;
	localparam int PADDR_W      = 3;
	localparam int NUM_STATES_W = 4;   // written field of num_states

	// Word index of the num_states register.
	localparam logic [PADDR_W-3:0] REG_NUM_STATES = '0;

	// Minus infinity and saturation bounds of the 32-bit result format.
	localparam logic [IN_W-1:0] MINF_32   = 32'h8000_0000;
	localparam logic [LP_W-1:0] LP_MAX_32 = 32'h7fff_ffff;
	localparam logic [LP_W-1:0] LP_LO_32  = 32'h8000_0001;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_UPDATE,
		ST_CHECK,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_LP,
		ST_TRACE
	} hvd_state_t;

	typedef struct packed {
		logic load;       // take the input word, read previous score
		logic add;        // saturating add
		logic update;     // compare, store, advance counters
		logic scan_init;  // reset best-score search
		logic scan_rd;    // read next final score
		logic lp_init;    // latch final score, load traceback start
		logic trace;      // emit one state, step back
		logic clear;      // start a fresh sequence
	} hvd_cmd_t;

	typedef struct packed {
		logic eos;
		logic step_zero;
		logic scan_last;
		logic t_zero;
	} hvd_status_t;

endpackage

`default_nettype wire

// ===== hdl/hvd_ctrl.sv =====
// ----------------------------------------------------------------------------
// HMM Viterbi decoder controller
// Sequences word processing, final score search and traceback.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hmm_viterbi_decoder_defines.svh"

module hvd_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire                  cfg_wr,
	input  hvd_pkg::hvd_status_t status,
	output logic                 busy,
	output hvd_pkg::hvd_cmd_t    cmd
);

	hvd_pkg::hvd_state_t state_q;
	hvd_pkg::hvd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hvd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hvd_pkg::ST_IDLE: begin
				if (start) state_d = hvd_pkg::ST_ADD;
			end
			hvd_pkg::ST_ADD:    state_d = hvd_pkg::ST_UPDATE;
			hvd_pkg::ST_UPDATE: begin
				state_d = status.eos ? hvd_pkg::ST_CHECK : hvd_pkg::ST_IDLE;
			end
			hvd_pkg::ST_CHECK: begin
				state_d = status.step_zero ? hvd_pkg::ST_IDLE : hvd_pkg::ST_SCAN;
			end
			hvd_pkg::ST_SCAN: begin
				if (status.scan_last) state_d = hvd_pkg::ST_SCAN_LAST;
			end
			hvd_pkg::ST_SCAN_LAST: state_d = hvd_pkg::ST_LP;
			hvd_pkg::ST_LP:        state_d = hvd_pkg::ST_TRACE;
			hvd_pkg::ST_TRACE: begin
				if (status.t_zero) state_d = hvd_pkg::ST_IDLE;
			end
			default: state_d = hvd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != hvd_pkg::ST_IDLE);
		case (state_q)
			hvd_pkg::ST_IDLE: begin
				cmd.load  = start;
				cmd.clear = cfg_wr;
			end
			hvd_pkg::ST_ADD:    cmd.add = 1'b1;
			hvd_pkg::ST_UPDATE: cmd.update = 1'b1;
			hvd_pkg::ST_CHECK: begin
				cmd.scan_init = 1'b1;
				cmd.clear     = status.step_zero;
			end
			hvd_pkg::ST_SCAN:      cmd.scan_rd = 1'b1;
			hvd_pkg::ST_SCAN_LAST: cmd = '0;
			hvd_pkg::ST_LP:        cmd.lp_init = 1'b1;
			hvd_pkg::ST_TRACE: begin
				cmd.trace = 1'b1;
				cmd.clear = status.t_zero;
			end
			default: cmd = '0;
		endcase
	end

	`HVD_ASSERT(a_cmd_exclusive, 1'b1, $onehot0({cmd.load, cmd.add, cmd.update, cmd.scan_rd, cmd.lp_init, cmd.trace}), "controller issued two datapath operations at once")
	`HVD_ASSERT_NEXT(a_add_then_update, cmd.add, cmd.update, "add not followed by update")
	`HVD_ASSERT_NEXT(a_trace_ends_idle, cmd.trace && status.t_zero, !busy, "traceback did not return to idle")

endmodule

`default_nettype wire

// ===== hdl/hvd_datapath.sv =====
// ----------------------------------------------------------------------------
// HMM Viterbi decoder datapath
// Score banks, saturating add-compare, backpointer store, best-score search
// and traceback registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hmm_viterbi_decoder_defines.svh"

module hvd_datapath #(
	parameter int MAX_STATES  = 8,
	parameter int MAX_STEPS   = 64,
	parameter int SCORE_WIDTH = 32,
	localparam int NW = $clog2(MAX_STATES + 1)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  hvd_pkg::hvd_cmd_t            cmd,
	output hvd_pkg::hvd_status_t         status,
	input  wire [NW-1:0]                 num_states,
	input  wire [hvd_pkg::IN_W-1:0]      log_potential,
	input  wire                          end_of_sequence,
	output logic                         valid,
	output logic [hvd_pkg::STATE_W-1:0]  state_index,
	output logic [hvd_pkg::LP_W-1:0]     path_score,
	output logic                         overflow,
	output logic                         last
);

	localparam int SW  = $clog2(MAX_STATES);
	localparam int TW  = $clog2(MAX_STEPS);
	localparam int CW  = $clog2(MAX_STEPS + 1);
	localparam int STW = hvd_pkg::STATE_W;
	localparam int XW  = ((SCORE_WIDTH > hvd_pkg::IN_W) ? SCORE_WIDTH : hvd_pkg::IN_W) + 1;

	localparam logic [SCORE_WIDTH-1:0] S_NEG = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
	localparam logic [SCORE_WIDTH-1:0] S_MAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
	localparam logic [SCORE_WIDTH-1:0] S_LO  = {1'b1, {(SCORE_WIDTH-2){1'b0}}, 1'b1};
	localparam logic [XW-1:0] X_MAX   = {{(XW-SCORE_WIDTH){1'b0}}, S_MAX};
	localparam logic [XW-1:0] X_LO    = {{(XW-SCORE_WIDTH){1'b1}}, S_LO};
	localparam logic [XW-1:0] X_LPMAX = {{(XW-hvd_pkg::LP_W){1'b0}}, hvd_pkg::LP_MAX_32};
	localparam logic [XW-1:0] X_LPLO  = {{(XW-hvd_pkg::LP_W){1'b1}}, hvd_pkg::LP_LO_32};

	// score banks: {bank, state}; the bank of bank_q holds the previous step
	logic [SCORE_WIDTH-1:0] score_mem [2**(SW+1)];
	logic [STW-1:0]         bp_unused_w;
	logic [SW-1:0]          bp_mem [2**(TW+SW)];

	logic [CW-1:0]          step_q;
	logic [SW-1:0]          src_q;
	logic [SW-1:0]          dst_q;
	logic                   bank_q;
	logic [SCORE_WIDTH-1:0] run_max_q;
	logic [SW-1:0]          run_arg_q;
	logic                   ovf_q;
	logic [SW-1:0]          scan_idx_q;
	logic                   scan_v_s1;
	logic                   valid_q;

	logic [SCORE_WIDTH-1:0] p_s1;
	logic                   eos_s1;
	logic [SCORE_WIDTH-1:0] rd_s1;
	logic [SCORE_WIDTH-1:0] sum_s2;
	logic [SW-1:0]          idx_s1;
	logic [SCORE_WIDTH-1:0] best_q;
	logic [SW-1:0]          best_st_q;
	logic [hvd_pkg::LP_W-1:0] lp_q;
	logic [TW-1:0]          t_q;
	logic [SW-1:0]          st_q;
	logic [STW-1:0]         state_out_q;
	logic                   last_out_q;
	logic                   ovf_out_q;

	logic [NW-1:0]          n_m1;
	logic                   step_full;
	logic                   step0;
	logic                   src_end;
	logic                   dst_end;
	logic [XW-1:0]          raw_x;
	logic [SCORE_WIDTH-1:0] p_in;
	logic [SCORE_WIDTH:0]   sum_w;
	logic [SCORE_WIDTH-1:0] sat_sum;
	logic                   gt;
	logic [SCORE_WIDTH-1:0] new_max;
	logic [SW-1:0]          new_arg;
	logic                   score_we;
	logic [SW:0]            score_waddr;
	logic [SCORE_WIDTH-1:0] score_wdata;
	logic                   score_re;
	logic [SW:0]            score_raddr;
	logic                   bp_we;
	logic                   finish;
	logic [XW-1:0]          best_x;
	logic [hvd_pkg::LP_W-1:0] lp_d;

	assign n_m1      = num_states - NW'(1);
	assign step_full = (step_q >= CW'(MAX_STEPS));
	assign step0     = (step_q == '0);
	assign src_end   = (NW'(src_q) == n_m1);
	assign dst_end   = (NW'(dst_q) == n_m1);

	// input saturation into the score range, minus infinity kept
	always_comb begin
		raw_x = {{(XW-hvd_pkg::IN_W){log_potential[hvd_pkg::IN_W-1]}}, log_potential};
		if (log_potential == hvd_pkg::MINF_32) begin
			p_in = S_NEG;
		end else if ($signed(raw_x) > $signed(X_MAX)) begin
			p_in = S_MAX;
		end else if ($signed(raw_x) < $signed(X_LO)) begin
			p_in = S_LO;
		end else begin
			p_in = raw_x[SCORE_WIDTH-1:0];
		end
	end

	// saturating add; minus infinity absorbs
	always_comb begin
		sum_w = {rd_s1[SCORE_WIDTH-1], rd_s1} + {p_s1[SCORE_WIDTH-1], p_s1};
		if (rd_s1 == S_NEG || p_s1 == S_NEG) begin
			sat_sum = S_NEG;
		end else if (sum_w[SCORE_WIDTH] != sum_w[SCORE_WIDTH-1]) begin
			sat_sum = sum_w[SCORE_WIDTH] ? S_LO : S_MAX;
		end else if (sum_w[SCORE_WIDTH-1:0] == S_NEG) begin
			sat_sum = S_LO;
		end else begin
			sat_sum = sum_w[SCORE_WIDTH-1:0];
		end
	end

	// strict greater keeps the lowest source on ties
	assign gt      = ($signed(sum_s2) > $signed(run_max_q));
	assign new_max = gt ? sum_s2 : run_max_q;
	assign new_arg = gt ? src_q : run_arg_q;

	assign score_we    = cmd.update && !step_full && (step0 || src_end);
	assign score_waddr = {~bank_q, dst_q};
	assign score_wdata = step0 ? p_s1 : new_max;
	assign bp_we       = cmd.update && !step_full && !step0 && src_end;
	assign finish      = score_we && dst_end;
	assign score_re    = cmd.load || cmd.scan_rd;
	assign score_raddr = cmd.load ? {bank_q, src_q} : {bank_q, scan_idx_q};

	always_ff @(posedge clk) begin
		if (score_we) score_mem[score_waddr] <= score_wdata;
	end

	always_ff @(posedge clk) begin
		if (score_re) rd_s1 <= score_mem[score_raddr];
	end

	always_ff @(posedge clk) begin
		if (bp_we) bp_mem[{step_q[TW-1:0], dst_q}] <= new_arg;
	end

	// traceback state: start from the best final state, then follow backpointers
	always_ff @(posedge clk) begin
		if (cmd.lp_init) begin
			st_q <= best_st_q;
		end else if (cmd.trace) begin
			st_q <= bp_mem[{t_q, st_q}];
		end
	end

	// sequence control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			bank_q     <= 1'b0;
			run_max_q  <= S_NEG;
			run_arg_q  <= '0;
			ovf_q      <= 1'b0;
			scan_idx_q <= '0;
			scan_v_s1  <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan_rd;
			valid_q   <= cmd.trace;
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + SW'(1);
			end
			if (cmd.clear) begin
				step_q    <= '0;
				src_q     <= '0;
				dst_q     <= '0;
				run_max_q <= S_NEG;
				run_arg_q <= '0;
				ovf_q     <= 1'b0;
			end else if (cmd.update) begin
				if (step_full) begin
					ovf_q <= 1'b1;
				end else if (step0) begin
					dst_q <= dst_end ? '0 : dst_q + SW'(1);
				end else if (src_end) begin
					run_max_q <= S_NEG;
					run_arg_q <= '0;
					src_q     <= '0;
					dst_q     <= dst_end ? '0 : dst_q + SW'(1);
				end else begin
					run_max_q <= new_max;
					run_arg_q <= new_arg;
					src_q     <= src_q + SW'(1);
				end
				if (finish) begin
					bank_q <= ~bank_q;
					step_q <= step_q + CW'(1);
				end
			end
		end
	end

	// final score saturation into 32 bits
	always_comb begin
		best_x = {{(XW-SCORE_WIDTH){best_q[SCORE_WIDTH-1]}}, best_q};
		if (best_q == S_NEG) begin
			lp_d = hvd_pkg::MINF_32;
		end else if ($signed(best_x) > $signed(X_LPMAX)) begin
			lp_d = hvd_pkg::LP_MAX_32;
		end else if ($signed(best_x) < $signed(X_LPLO)) begin
			lp_d = hvd_pkg::LP_LO_32;
		end else begin
			lp_d = best_x[hvd_pkg::LP_W-1:0];
		end
	end

	assign bp_unused_w = STW'(st_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_s1   <= p_in;
			eos_s1 <= end_of_sequence;
		end
		if (cmd.add) sum_s2 <= sat_sum;
		if (cmd.scan_rd) idx_s1 <= scan_idx_q;
		if (cmd.scan_init) begin
			best_q    <= S_NEG;
			best_st_q <= '0;
		end else if (scan_v_s1 && ($signed(rd_s1) > $signed(best_q))) begin
			best_q    <= rd_s1;
			best_st_q <= idx_s1;
		end
		if (cmd.lp_init) begin
			lp_q <= lp_d;
			t_q  <= TW'(step_q - CW'(1));
		end else if (cmd.trace) begin
			t_q <= t_q - TW'(1);
		end
		if (cmd.trace) begin
			state_out_q <= bp_unused_w;
			last_out_q  <= (t_q == '0);
			ovf_out_q   <= ovf_q;
		end
	end

	assign status.eos       = eos_s1;
	assign status.step_zero = step0;
	assign status.scan_last = (NW'(scan_idx_q) == n_m1);
	assign status.t_zero    = (t_q == '0);

	assign valid       = valid_q;
	assign state_index = state_out_q;
	assign path_score  = lp_q;
	assign overflow    = ovf_out_q;
	assign last        = last_out_q;

	`HVD_ASSERT(a_src_in_range, 1'b1, NW'(src_q) < num_states, "source counter beyond state count")
	`HVD_ASSERT(a_dst_in_range, 1'b1, NW'(dst_q) < num_states, "destination counter beyond state count")

endmodule

`default_nettype wire

// ===== hdl/hmm_viterbi_decoder.sv =====
// ----------------------------------------------------------------------------
// HMM Viterbi decoder
// Log-domain Viterbi decoding of a streamed HMM trellis with traceback.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------------
//  input     | start / busy               | log_potential, end_of_sequence
//  result    | valid (one-cycle strobe)   | state_index, path_score,
//            |                            | overflow, last
//  config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  Each input word passes accept (read the previous score bank), saturating
//  add, then compare and store, the order set by the single score bank read
//  port and the add-compare path. On a word with end_of_sequence set, a
//  check step follows; with no step stored the decoder returns to idle with
//  no results, else the best-score search (one score bank read per cycle)
//  runs, the final score is latched, then one result per cycle, one per
//  stored step, comes from the backpointer store. busy stays high from
//  accept until the cycle in which the last result is on the ports; busy is
//  low in that cycle. Results cannot be stalled: each is on the ports for a
//  single cycle. Reset is asynchronous, active low; no clearing pass needed.
//
//  Score banks ping-pong between "previous" and "next" so no copy is made at
//  a step boundary. Backpointers live in a MAX_STEPS x state memory that is
//  never cleared: every entry whose value the traceback uses was written in
//  the same sequence.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hmm_viterbi_decoder_defines.svh"

module hmm_viterbi_decoder #(
	parameter int MAX_STATES  = 8,
	parameter int MAX_STEPS   = 64,
	parameter int SCORE_WIDTH = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration port
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [hvd_pkg::PADDR_W-1:0]       paddr,
	input  wire  [hvd_pkg::APB_DW-1:0]        pwdata,
	output logic [hvd_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	// input words
	input  wire                               start,
	output logic                              busy,
	input  wire  signed [hvd_pkg::IN_W-1:0]   log_potential,
	input  wire                               end_of_sequence,
	// result words
	output logic                              valid,
	output logic [hvd_pkg::STATE_W-1:0]       state_index,
	output logic signed [hvd_pkg::LP_W-1:0]   path_score,
	output logic                              overflow,
	output logic                              last
);

	localparam int NW    = $clog2(MAX_STATES + 1);
	localparam int N_RST = (MAX_STATES < 8) ? MAX_STATES : 8;

	logic [NW-1:0]                     num_states_q;
	logic [NW-1:0]                     num_states_d;
	logic [hvd_pkg::NUM_STATES_W-1:0]  cfg_v;
	logic                              cfg_wr;
	hvd_pkg::hvd_cmd_t                 cmd;
	hvd_pkg::hvd_status_t              status;

	// register write: word index from paddr, byte offset ignored
	assign cfg_wr = psel && penable && pwrite
	                && (paddr[hvd_pkg::PADDR_W-1:2] == hvd_pkg::REG_NUM_STATES);
	assign cfg_v  = pwdata[hvd_pkg::NUM_STATES_W-1:0];

	// clamp: zero acts as one state, anything above the build limit as the limit
	always_comb begin
		if (cfg_v == '0) begin
			num_states_d = NW'(1);
		end else if (int'(cfg_v) > MAX_STATES) begin
			num_states_d = NW'(MAX_STATES);
		end else begin
			num_states_d = NW'(cfg_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= NW'(N_RST);
		end else if (cfg_wr) begin
			num_states_q <= num_states_d;
		end
	end

	assign pready = 1'b1;
	assign prdata = hvd_pkg::APB_DW'(num_states_q);

	hvd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_wr (cfg_wr),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	hvd_datapath #(
		.MAX_STATES  (MAX_STATES),
		.MAX_STEPS   (MAX_STEPS),
		.SCORE_WIDTH (SCORE_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.num_states      (num_states_q),
		.log_potential   (log_potential),
		.end_of_sequence (end_of_sequence),
		.valid           (valid),
		.state_index     (state_index),
		.path_score      (path_score),
		.overflow        (overflow),
		.last            (last)
	);

	// a traceback emits its results back to back up to the one for step zero
	`HVD_ASSERT_NEXT(a_result_burst, valid && !last, valid, "gap inside a traceback burst")

endmodule

`default_nettype wire
